// ===== hw/rtl/flr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants of the line rasterizer
// Holds the fixed field widths, the register and function codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package flr_pkg;

    // fixed widths
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam int PIX_BITS     = 11;
    localparam int ACC_BITS     = 32;
    localparam int COLOR_BITS   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    // configuration reset values
    localparam logic [CFG_BITS-1:0] CANVAS_WIDTH_RST  = 12'd640;
    localparam logic [CFG_BITS-1:0] CANVAS_HEIGHT_RST = 12'd480;

    // request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;        // load request accepted
        logic step;        // step request accepted
        logic div_step;    // run one divider iteration
        logic div_finish;  // divider result is final this cycle
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_ok;     // endpoints on the canvas
        logic long_zero;   // single point line
        logic div_last;    // last divider iteration
        logic out_valid;   // output register occupied
    } t_ctrl_status;

endpackage
`default_nettype wire

// ===== hw/rtl/fixed_point_line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer: fixed-point line rasterizer top level
// Request channel (i_valid / o_stall) carries a function code, two
// endpoints and a color. A load request (func 0) checks both endpoints
// against the canvas registers and sets up the line; a step request
// (func 1) emits the next pixel on the result channel (o_valid / i_stall),
// with o_last_pixel set on the end point. A step with no line is dropped.
// Config channel (i_cfg_valid / o_cfg_ready) writes canvas width (index 0)
// and height (index 1); it is always ready.
// Timing: a step's pixel shows on o_valid the next cycle, so pixels stream at
// one per cycle while the receiver does not stall. A load of a line longer
// than one point runs the bit-serial slope divider; requests stall
// during that time.
// Reset: no line is active, canvas is 640 x 480, the result channel empty.
// When the receiver stalls, the pixel holds in the output register and new
// requests stall until it is taken.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer
    import flr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_func,
    input  wire logic signed [COORD_BITS-1:0] i_x_start,
    input  wire logic signed [COORD_BITS-1:0] i_y_start,
    input  wire logic signed [COORD_BITS-1:0] i_x_end,
    input  wire logic signed [COORD_BITS-1:0] i_y_end,
    input  wire logic [COLOR_BITS-1:0]        i_color,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [PIX_BITS-1:0]               o_pixel_x,
    output logic [PIX_BITS-1:0]               o_pixel_y,
    output logic [COLOR_BITS-1:0]             o_pixel_color,
    output logic                              o_last_pixel,
    // config channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [CFG_BITS-1:0]          i_cfg_data
);

    logic [CFG_BITS-1:0] r_canvas_width;
    logic [CFG_BITS-1:0] r_canvas_height;
    t_ctrl_cmd           cmd;
    t_ctrl_status        status;

    assign o_cfg_ready = 1'b1;

    // canvas registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= CANVAS_WIDTH_RST;
            r_canvas_height <= CANVAS_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH:  r_canvas_width  <= i_cfg_data;
                CFG_CANVAS_HEIGHT: r_canvas_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    flr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_stall  (i_stall),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    flr_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_canvas_width  (r_canvas_width),
        .i_canvas_height (r_canvas_height),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .i_color         (i_color),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/flr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_ctrl: request handshake and sequencing of the line rasterizer
// Accepts requests, issues load/step commands and walks the datapath's
// divider through its iterations after a line load.
// ----------------------------------------------------------------------------
module flr_ctrl
    import flr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic         i_func,
    input  wire logic         i_stall,
    output logic              o_stall,
    input  wire t_ctrl_status i_status,
    output t_ctrl_cmd         o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    logic r_state;
    logic n_state;
    logic out_free;
    logic accept;
    logic div_start;

    // the output register can take a pixel this cycle
    assign out_free = !i_status.out_valid || !i_stall;

    // hold off requests while dividing or while a pixel is blocked
    assign o_stall = (r_state != ST_IDLE) || !out_free;
    assign accept  = i_valid && !o_stall;

    // commands
    assign o_cmd.load       = accept && (i_func == FUNC_LOAD);
    assign o_cmd.step       = accept && (i_func == FUNC_STEP);
    assign o_cmd.div_step   = (r_state == ST_DIV);
    assign o_cmd.div_finish = (r_state == ST_DIV) && i_status.div_last;
    assign div_start        = o_cmd.load && i_status.load_ok && !i_status.long_zero;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (div_start) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // no request gets in while the divider runs
    a_div_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (o_stall && !o_cmd.load && !o_cmd.step))
        else $error("request accepted during division");

    // the divider always ends after its last iteration
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && i_status.div_last) |=> (r_state == ST_IDLE))
        else $error("divider did not return to idle");

    // a division starts only from a valid, non-degenerate load
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_IDLE) && $past(r_state == ST_IDLE) && (r_state == ST_IDLE))
        |-> ((n_state == ST_DIV) == div_start))
        else $error("unexpected division start");

endmodule
`default_nettype wire

// ===== hw/rtl/flr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flr_datapath: line geometry, slope divider and pixel stepper
// Checks and sets up a line on load, computes the fixed-point minor-axis
// increment one quotient bit per cycle, and steps out pixels into an
// output register.
// ----------------------------------------------------------------------------
module flr_datapath
    import flr_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_ctrl_cmd                    i_cmd,
    output t_ctrl_status                      o_status,
    input  wire logic [CFG_BITS-1:0]          i_canvas_width,
    input  wire logic [CFG_BITS-1:0]          i_canvas_height,
    input  wire logic signed [COORD_BITS-1:0] i_x_start,
    input  wire logic signed [COORD_BITS-1:0] i_y_start,
    input  wire logic signed [COORD_BITS-1:0] i_x_end,
    input  wire logic signed [COORD_BITS-1:0] i_y_end,
    input  wire logic [COLOR_BITS-1:0]        i_color,
    input  wire logic                         i_stall,
    output logic                              o_valid,
    output logic [PIX_BITS-1:0]               o_pixel_x,
    output logic [PIX_BITS-1:0]               o_pixel_y,
    output logic [COLOR_BITS-1:0]             o_pixel_color,
    output logic                              o_last_pixel
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int REM_W = MAG_W + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int CMP_W = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

    // line state
    logic                  r_line_active;
    logic                  r_major_is_y;
    logic                  r_major_desc;
    logic [COORD_BITS-1:0] r_major_pos;
    logic [COORD_BITS-1:0] r_major_stop;
    logic [ACC_BITS-1:0]   r_minor_acc;
    logic [ACC_BITS-1:0]   r_minor_inc;
    logic [COLOR_BITS-1:0] r_color;

    // divider state
    logic [REM_W-1:0] r_div_rem;
    logic [MAG_W-1:0] r_div_den;
    logic [Q_W-1:0]   r_div_q;
    logic [CNT_W-1:0] r_div_cnt;
    logic             r_div_neg;

    // output register
    logic                r_out_valid;
    logic [PIX_BITS-1:0] r_out_x;
    logic [PIX_BITS-1:0] r_out_y;
    logic [COLOR_BITS-1:0] r_out_color;
    logic                r_out_last;

    // endpoint checks
    logic [CMP_W-1:0] cw;
    logic [CMP_W-1:0] ch;
    logic             any_neg;
    logic             load_ok;

    // geometry of the incoming line
    logic signed [MAG_W-1:0] dx;
    logic signed [MAG_W-1:0] dy;
    logic [MAG_W-1:0]        adx;
    logic [MAG_W-1:0]        ady;
    logic                    y_major;
    logic [MAG_W-1:0]        long_s;
    logic [MAG_W-1:0]        short_s;
    logic [MAG_W-1:0]        long_mag;
    logic [MAG_W-1:0]        short_mag;
    logic                    long_zero;
    logic [COORD_BITS-1:0]   min0;
    logic [ACC_BITS-1:0]     acc_init;

    // divider iteration
    logic [REM_W-1:0]    div_trial;
    logic                div_ge;
    logic [Q_W-1:0]      div_q_next;
    logic [ACC_BITS-1:0] inc_mag;

    // stepping
    logic                emit;
    logic                at_last;
    logic [PIX_BITS-1:0] minor_pix;
    logic [PIX_BITS-1:0] major_pix;
    logic                out_taken;

    // reject negative coordinates and those at or past the canvas edge
    assign cw      = CMP_W'(i_canvas_width);
    assign ch      = CMP_W'(i_canvas_height);
    assign any_neg = i_x_start[COORD_BITS-1] | i_y_start[COORD_BITS-1]
                   | i_x_end[COORD_BITS-1] | i_y_end[COORD_BITS-1];
    assign load_ok = !any_neg
                   && (CMP_W'(unsigned'(i_x_start)) < cw)
                   && (CMP_W'(unsigned'(i_x_end)) < cw)
                   && (CMP_W'(unsigned'(i_y_start)) < ch)
                   && (CMP_W'(unsigned'(i_y_end)) < ch);

    // deltas and major axis choice
    assign dx  = {i_x_end[COORD_BITS-1], i_x_end} - {i_x_start[COORD_BITS-1], i_x_start};
    assign dy  = {i_y_end[COORD_BITS-1], i_y_end} - {i_y_start[COORD_BITS-1], i_y_start};
    assign adx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    assign ady = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    assign y_major   = ady > adx;
    assign long_s    = y_major ? dy : dx;
    assign short_s   = y_major ? dx : dy;
    assign long_mag  = y_major ? ady : adx;
    assign short_mag = y_major ? adx : ady;
    assign long_zero = (long_mag == '0);
    assign min0      = y_major ? i_x_start : i_y_start;
    assign acc_init  = (ACC_BITS'(min0) << FRAC_BITS) + (ACC_BITS'(1) << (FRAC_BITS - 1));

    // restoring divider: first iteration uses the short length as is
    assign div_trial  = (r_div_cnt == CNT_W'(FRAC_BITS)) ? r_div_rem : (r_div_rem << 1);
    assign div_ge     = div_trial >= REM_W'(r_div_den);
    assign div_q_next = {r_div_q[Q_W-2:0], div_ge};
    assign inc_mag    = ACC_BITS'(div_q_next);

    // pixel coordinates from the current position
    assign emit      = i_cmd.step && r_line_active;
    assign at_last   = (r_major_pos == r_major_stop);
    assign minor_pix = r_minor_acc[FRAC_BITS +: PIX_BITS];
    assign major_pix = PIX_BITS'(r_major_pos);
    assign out_taken = r_out_valid && !i_stall;

    // status
    assign o_status.load_ok   = load_ok;
    assign o_status.long_zero = long_zero;
    assign o_status.div_last  = (r_div_cnt == '0);
    assign o_status.out_valid = r_out_valid;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_line_active <= load_ok && long_zero;
            end else if (i_cmd.div_finish) begin
                r_line_active <= 1'b1;
            end else if (emit && at_last) begin
                r_line_active <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // line setup, division and stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && load_ok) begin
            r_major_is_y <= y_major;
            r_major_desc <= long_s[MAG_W-1] || long_zero;
            r_major_pos  <= y_major ? i_y_start : i_x_start;
            r_major_stop <= y_major ? i_y_end : i_x_end;
            r_minor_acc  <= acc_init;
            r_minor_inc  <= '0;
            r_color      <= i_color;
            r_div_rem    <= REM_W'(short_mag);
            r_div_den    <= long_mag;
            r_div_q      <= '0;
            r_div_cnt    <= CNT_W'(FRAC_BITS);
            r_div_neg    <= short_s[MAG_W-1] ^ long_s[MAG_W-1];
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? (div_trial - REM_W'(r_div_den)) : div_trial;
            r_div_q   <= div_q_next;
            r_div_cnt <= r_div_cnt - CNT_W'(1);
            if (i_cmd.div_finish) begin
                r_minor_inc <= r_div_neg ? (-inc_mag) : inc_mag;
            end
        end else if (emit && !at_last) begin
            if (r_major_desc) begin
                r_major_pos <= r_major_pos - COORD_BITS'(1);
                r_minor_acc <= r_minor_acc - r_minor_inc;
            end else begin
                r_major_pos <= r_major_pos + COORD_BITS'(1);
                r_minor_acc <= r_minor_acc + r_minor_inc;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= r_major_is_y ? minor_pix : major_pix;
            r_out_y     <= r_major_is_y ? major_pix : minor_pix;
            r_out_color <= r_color;
            r_out_last  <= at_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

    // a step on an active line always yields a pixel next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("pixel lost after step");

    // a step never lands on an occupied, stalled output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> (!r_out_valid || !i_stall))
        else $error("pixel overwritten in output register");

    // a finished division leaves an active line
    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_finish |=> r_line_active)
        else $error("line not active after division");

endmodule
`default_nettype wire

// ===== verif/fixed_point_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_line_rasterizer_tb: self-checking bench for the line rasterizer
// Loads lines and steps pixels out through the request channel. Each pixel is
// checked against a line stepper kept inside the bench, which applies the same
// canvas rejection and 16.16 minor-axis slope. Canvas registers are changed
// between tests while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module fixed_point_line_rasterizer_tb;
    import flr_pkg::*;

    localparam int COORD_W        = 12;
    localparam int FRAC_W         = 16;
    localparam int DRAIN_CYCLES   = 24;    // divider pass plus output register
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [PIX_BITS-1:0]   x;
        logic [PIX_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pixel;

    // DUT ports
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic                       o_stall;
    logic                       i_func      = FUNC_LOAD;
    logic signed [COORD_W-1:0]  i_x_start   = '0;
    logic signed [COORD_W-1:0]  i_y_start   = '0;
    logic signed [COORD_W-1:0]  i_x_end     = '0;
    logic signed [COORD_W-1:0]  i_y_end     = '0;
    logic [COLOR_BITS-1:0]      i_color     = '0;
    logic                       o_valid;
    logic                       i_stall     = 1'b0;
    logic [PIX_BITS-1:0]        o_pixel_x;
    logic [PIX_BITS-1:0]        o_pixel_y;
    logic [COLOR_BITS-1:0]      o_pixel_color;
    logic                       o_last_pixel;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index = CFG_CANVAS_WIDTH;
    logic [CFG_BITS-1:0]        i_cfg_data  = '0;

    // predictor state
    logic                  trace_active;
    logic                  trace_major_y;
    logic                  trace_down;
    logic [COORD_W-1:0]    trace_pos;
    logic [COORD_W-1:0]    trace_stop;
    logic [31:0]           trace_acc;
    logic [31:0]           trace_inc;
    logic [COLOR_BITS-1:0] trace_color;
    logic [CFG_BITS-1:0]   canvas_w;
    logic [CFG_BITS-1:0]   canvas_h;

    t_pixel expected_pixels[$];

    // idling mix and run statistics
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int requests_sent  = 0;
    int working_items  = 0;
    int lines_loaded   = 0;
    int lines_rejected = 0;
    int pixels_checked = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    fixed_point_line_rasterizer #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS (FRAC_W)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_color      (i_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_last_pixel (o_last_pixel),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Load: reject off-canvas lines, pick the major axis, set up the slope
    function automatic void trace_load(logic signed [COORD_W-1:0] xs, ys, xe, ye,
                                       logic [COLOR_BITS-1:0] color);
        int     x0, y0, x1, y1;
        int     d_minor, d_major, maj0, min0, t;
        longint slope;
        x0 = xs;
        y0 = ys;
        x1 = xe;
        y1 = ye;
        trace_active = 1'b0;
        if (x0 < 0 || y0 < 0 || x1 < 0 || y1 < 0 ||
            x0 >= int'(canvas_w) || x1 >= int'(canvas_w) ||
            y0 >= int'(canvas_h) || y1 >= int'(canvas_h)) begin
            lines_rejected++;
            return;
        end
        d_minor = y1 - y0;
        d_major = x1 - x0;
        maj0 = x0;
        min0 = y0;
        trace_major_y = 1'b0;
        if (iabs(d_minor) > iabs(d_major)) begin
            t = d_minor;
            d_minor = d_major;
            d_major = t;
            maj0 = y0;
            min0 = x0;
            trace_major_y = 1'b1;
        end
        // 16.16 slope, truncated toward zero
        if (d_major == 0)
            slope = 0;
        else
            slope = (longint'(d_minor) * (64'sd1 << FRAC_W)) / longint'(d_major);
        trace_inc    = slope[31:0];
        trace_acc    = (32'd1 << (FRAC_W - 1)) + (32'(min0) << FRAC_W);
        trace_down   = !(d_major > 0);
        trace_pos    = COORD_W'(maj0);
        trace_stop   = COORD_W'(maj0 + d_major);
        trace_color  = color;
        trace_active = 1'b1;
        lines_loaded++;
    endfunction

    // Step: emit the current pixel and advance along the major axis
    function automatic bit trace_step(output t_pixel px);
        logic [15:0] minor;
        px = '0;
        if (!trace_active) return 1'b0;
        minor    = trace_acc[31:16];
        px.x     = trace_major_y ? minor[PIX_BITS-1:0] : trace_pos[PIX_BITS-1:0];
        px.y     = trace_major_y ? trace_pos[PIX_BITS-1:0] : minor[PIX_BITS-1:0];
        px.color = trace_color;
        px.last  = (trace_pos == trace_stop);
        if (px.last) begin
            trace_active = 1'b0;
        end else if (trace_down) begin
            trace_pos = trace_pos - 1'b1;
            trace_acc = trace_acc - trace_inc;
        end else begin
            trace_pos = trace_pos + 1'b1;
            trace_acc = trace_acc + trace_inc;
        end
        return 1'b1;
    endfunction

    // One request: optional idle gap, then hold until accepted
    task automatic send_request(logic func, logic signed [COORD_W-1:0] xs, ys, xe, ye,
                                logic [COLOR_BITS-1:0] color);
        int     gap;
        t_pixel px;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_func    <= func;
        i_x_start <= xs;
        i_y_start <= ys;
        i_x_end   <= xe;
        i_y_end   <= ye;
        i_color   <= color;
        do @(posedge i_clk); while (o_stall);
        requests_sent++;
        if (func == FUNC_LOAD) begin
            trace_load(xs, ys, xe, ye, color);
            working_items++;
        end else if (trace_step(px)) begin
            expected_pixels.push_back(px);
            working_items++;
        end
    endtask

    // step payload is don't-care, so it carries random noise
    task automatic send_step();
        send_request(FUNC_STEP, COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), COORD_W'($urandom), $urandom);
    endtask

    task automatic draw_line(int xs, ys, xe, ye, logic [COLOR_BITS-1:0] color, int steps);
        send_request(FUNC_LOAD, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe), COORD_W'(ye),
                     color);
        repeat (steps) send_step();
    endtask

    // drain all pending pixels, then let any slope division finish
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_canvas(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_CANVAS_WIDTH;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        canvas_w = w;
        i_cfg_index <= CFG_CANVAS_HEIGHT;
        i_cfg_data  <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        canvas_h = h;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly whole on-canvas lines, plus noise loads, stray steps,
    // lines cut short by a new load and extra steps past the end point.
    task automatic run_random_lines(int target);
        int base, kind, lx, ly, xs, ys, xe, ye, span, steps, r;
        base = working_items;
        while (working_items - base < target) begin
            kind = $urandom_range(99);
            lx = (canvas_w > 2048) ? 2048 : int'(canvas_w);
            ly = (canvas_h > 2048) ? 2048 : int'(canvas_h);
            if (kind < 8 || lx == 0 || ly == 0) begin
                send_request(FUNC_LOAD, COORD_W'($urandom), COORD_W'($urandom),
                             COORD_W'($urandom), COORD_W'($urandom), $urandom);
                steps = $urandom_range(3);
            end else if (kind < 14) begin
                steps = $urandom_range(1, 3);
            end else begin
                span = ($urandom_range(99) < 5) ? 200 : 12;
                xs = $urandom_range(lx - 1);
                ys = $urandom_range(ly - 1);
                xe = clamp_coord(xs + $urandom_range(2 * span) - span, lx - 1);
                ye = clamp_coord(ys + $urandom_range(2 * span) - span, ly - 1);
                steps = ((iabs(xe - xs) > iabs(ye - ys)) ? iabs(xe - xs) : iabs(ye - ys)) + 1;
                r = $urandom_range(99);
                if (r < 10)
                    steps = $urandom_range(1, steps);
                else if (r < 20)
                    steps = steps + $urandom_range(1, 2);
                send_request(FUNC_LOAD, COORD_W'(xs), COORD_W'(ys), COORD_W'(xe),
                             COORD_W'(ye), $urandom);
            end
            repeat (steps) send_step();
        end
    endtask

    // ---- tests ----

    // corner cases at the reset canvas of 640 x 480
    task automatic test_directed_cases();
        send_step();                                        // no line yet
        draw_line(0, 0, 0, 0, 32'h0000_0000, 2);            // single point, extra step
        draw_line(639, 479, 639, 479, 32'hFFFF_FFFF, 1);    // far corner point
        draw_line(-2048, 0, 5, 5, 32'h1234_5678, 1);        // negative start
        draw_line(3, 3, 640, 3, 32'hA5A5_A5A5, 0);          // x on canvas width
        draw_line(3, 3, 3, 480, 32'h5A5A_5A5A, 0);          // y on canvas height
        draw_line(3, 3, 5, -1, 32'hDEAD_BEEF, 0);           // negative end row
        draw_line(100, 100, 107, 100, 32'h00FF_00FF, 2);    // cut short by next load
        draw_line(6, 1, 4, 5, 32'hFF00_FF00, 5);            // steep, minor descending
        draw_line(5, 5, 1, 3, 32'h0F0F_0F0F, 5);            // major axis descending
    endtask

    task automatic test_reset_canvas();
        run_random_lines(90);
    endtask

    task automatic test_full_canvas();
        write_canvas(12'd4095, 12'd4095);
        run_random_lines(90);
    endtask

    task automatic test_max_canvas();
        write_canvas(12'd2048, 12'd2048);
        run_random_lines(80);
    endtask

    task automatic test_unit_canvas();
        write_canvas(12'd1, 12'd1);
        run_random_lines(30);
    endtask

    // a zero-sized axis rejects every line
    task automatic test_zero_canvas();
        write_canvas(12'd0, 12'd2048);
        run_random_lines(20);
        write_canvas(12'd2048, 12'd0);
        run_random_lines(20);
    endtask

    task automatic test_random_canvas();
        repeat (4) begin
            write_canvas(CFG_BITS'($urandom_range(1, 2048)), CFG_BITS'($urandom_range(1, 2048)));
            run_random_lines(30);
        end
    endtask

    // ---- result side ----

    // random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic report_mismatch(t_pixel want, t_pixel got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"pixel mismatch: want x=%0d y=%0d color=%h last=%0d,",
                      " got x=%0d y=%0d color=%h last=%0d"},
                     want.x, want.y, want.color, want.last, got.x, got.y, got.color, got.last);
    endtask

    // compare each accepted pixel with the oldest expectation
    always @(posedge i_clk) begin : check_pixels
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{x: o_pixel_x, y: o_pixel_y, color: o_pixel_color, last: o_last_pixel};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel x=%0d y=%0d color=%h last=%0d",
                             got.x, got.y, got.color, got.last);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.x !== want.x || got.y !== want.y ||
                    got.color !== want.color || got.last !== want.last)
                    report_mismatch(want, got);
            end
        end
    end

    // watchdog: too long with no request, pixel or register write accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("fixed_point_line_rasterizer_tb: FAIL");
            $finish;
        end
    end

    // ---- sequence ----
    initial begin
        canvas_w      = CANVAS_WIDTH_RST;
        canvas_h      = CANVAS_HEIGHT_RST;
        trace_active  = 1'b0;
        trace_major_y = 1'b0;
        trace_down    = 1'b0;
        trace_pos     = '0;
        trace_stop    = '0;
        trace_acc     = '0;
        trace_inc     = '0;
        trace_color   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender lightly idle, receiver heavily stalled
        send_idle_pct = 27;
        recv_idle_pct = 87;
        test_directed_cases();
        test_reset_canvas();
        test_full_canvas();

        // sender heavily idle, receiver lightly stalled
        send_idle_pct = 87;
        recv_idle_pct = 27;
        test_max_canvas();
        test_unit_canvas();
        test_zero_canvas();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_canvas();

        wait_idle();
        if (expected_pixels.size() != 0) begin
            mismatches += expected_pixels.size();
            $display("%0d expected pixels never arrived", expected_pixels.size());
        end
        $display("ran %0d requests: %0d lines loaded, %0d rejected, %0d pixels checked",
                 requests_sent, lines_loaded, lines_rejected, pixels_checked);
        $display("canvas sizes from 0 to 4095 under three idling mixes, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("fixed_point_line_rasterizer_tb: PASS");
        else
            $display("fixed_point_line_rasterizer_tb: FAIL");
        $finish;
    end

endmodule
